// ===== hw/rtl/region_rectangle_overlap_table_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the region rectangle overlap table
// Clocked assertion wrappers that compile to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef REGION_RECTANGLE_OVERLAP_TABLE_ASSERT_SVH
`define REGION_RECTANGLE_OVERLAP_TABLE_ASSERT_SVH
`ifndef SYNTH
// Property must hold at every rising clock edge outside reset.
`define RROT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("region table assertion failed");
// Condition must never be true at a rising clock edge outside reset.
`define RROT_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("region table forbidden condition seen");
`else
`define RROT_ASSERT(lbl, clk, rst_n, prop)
`define RROT_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== hw/rtl/rrot_pkg.sv =====
// ----------------------------------------------------------------------------
// Region rectangle overlap table package
// Table size, command codes, widths and bound types shared by the block.
// ----------------------------------------------------------------------------
package rrot_pkg;

  // Table size and result limit per command.
  localparam int DEPTH        = 16;
  localparam int RESULT_LIMIT = 16;

  localparam int IDXW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);
  localparam int NW   = $clog2(RESULT_LIMIT + 1);

  localparam logic [CNTW-1:0] COUNT_FULL = CNTW'(DEPTH);
  localparam logic [NW-1:0]   LIMIT_N    = NW'(RESULT_LIMIT);

  // Command codes.
  localparam logic [2:0] CMD_CLEAR      = 3'd0;
  localparam logic [2:0] CMD_INSERT     = 3'd1;
  localparam logic [2:0] CMD_POINT      = 3'd2;
  localparam logic [2:0] CMD_ANY_WINDOW = 3'd3;
  localparam logic [2:0] CMD_ALL_REACH  = 3'd4;
  localparam logic [2:0] CMD_X_INTERVAL = 3'd5;

  // Span values of an empty table.
  localparam logic signed [15:0] SPAN_LOW_EMPTY  = 16'sh7FFF;
  localparam logic signed [15:0] SPAN_HIGH_EMPTY = 16'sh8000;
  localparam logic signed [15:0] COORD_MIN       = 16'sh8000;
  localparam logic signed [15:0] COORD_MAX       = 16'sh7FFF;

  // Inclusive rectangle bounds of one region.
  typedef struct packed {
    logic signed [15:0] max_y;
    logic signed [15:0] max_x;
    logic signed [15:0] min_y;
    logic signed [15:0] min_x;
  } bounds_t;

endpackage

// ===== hw/rtl/region_rectangle_overlap_table.sv =====
// ----------------------------------------------------------------------------
// Region rectangle overlap table
// Stores up to DEPTH rectangles and answers insert and overlap queries.
// ----------------------------------------------------------------------------
// One command is taken at a time. After the transfer that brings it in, the
// sequencer walks the stored regions in insertion order with a single shared
// compare unit, one region per cycle while the result output does not hold it,
// then finishes and returns to idle to take the next command; a first-match
// query stops at its hit and an insert at a duplicate id. Clear and undefined
// commands skip the walk. Commands 4 and 5 emit one result per match, up to
// RESULT_LIMIT, or a single miss result; a stalled result output holds the
// walk on the next match.
`include "region_rectangle_overlap_table_assert.svh"

module region_rectangle_overlap_table
  import rrot_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // From bit 0: region_id[8], level[16], ax[16], ay[16], bx[16], by[16],
  // reach_north[8], reach_south[8], reach_east[8], reach_west[8].
  input  logic [119:0] s_axis_tdata,
  // From bit 0: cmd[3].
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // From bit 0: match_id[8], span_low[16], span_high[16].
  output logic [39:0]  m_axis_tdata,
  // From bit 0: hit[1].
  output logic         m_axis_tuser,
  // Marks the final result of a command.
  output logic         m_axis_tlast
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  // Input field slices.
  logic        [7:0]  in_rid;
  logic signed [15:0] in_level, in_ax, in_ay, in_bx, in_by;
  logic signed [7:0]  in_north, in_south, in_east, in_west;

  assign in_rid   = s_axis_tdata[7:0];
  assign in_level = s_axis_tdata[23:8];
  assign in_ax    = s_axis_tdata[39:24];
  assign in_ay    = s_axis_tdata[55:40];
  assign in_bx    = s_axis_tdata[71:56];
  assign in_by    = s_axis_tdata[87:72];
  assign in_north = s_axis_tdata[95:88];
  assign in_south = s_axis_tdata[103:96];
  assign in_east  = s_axis_tdata[111:104];
  assign in_west  = s_axis_tdata[119:112];

  // Sequencer and request registers.
  state_e                 state_q, state_d;
  logic [2:0]             cmd_q, cmd_d;
  logic [7:0]             rid_q, rid_d;
  logic signed [15:0]     lvl_q, lvl_d;
  logic signed [15:0]     x0_q, x0_d, y0_q, y0_d, x1_q, x1_d, y1_q, y1_d;
  logic [CNTW-1:0]        idx_q, idx_d;
  logic [NW-1:0]          n_q, n_d;
  logic                   pend_q, pend_d;
  logic [7:0]             pid_q, pid_d;
  logic                   dup_q, dup_d;
  logic [CNTW-1:0]        count_q, count_d;
  logic signed [15:0]     span_low_q, span_low_d, span_high_q, span_high_d;

  // Output register.
  logic                   out_valid_q, out_valid_d;
  logic                   out_hit_q, out_hit_d;
  logic [7:0]             out_id_q, out_id_d;
  logic                   out_last_q, out_last_d;
  logic signed [15:0]     out_low_q, out_low_d, out_high_q, out_high_d;

  // Region storage, written in insertion order.
  logic [7:0]             entry_id_q    [DEPTH];
  logic signed [15:0]     entry_level_q [DEPTH];
  bounds_t                entry_bounds_q[DEPTH];
  logic                   wr_en;

  // Shared compare unit over the entry under the walk pointer.
  logic [IDXW-1:0]        eidx;
  bounds_t                eb;
  logic                   lvl_ok, ov, cand_hit, id_eq, at_end, out_free;
  logic                   multi, use_level, ins_ok;

  // Terms watched by the checks.
  logic                   spans_empty, out_partial, out_miss;

  assign eidx      = idx_q[IDXW-1:0];
  assign eb        = entry_bounds_q[eidx];
  assign use_level = (cmd_q != CMD_X_INTERVAL);
  assign lvl_ok    = !use_level || (entry_level_q[eidx] == lvl_q);
  assign ov        = (eb.max_x >= x0_q) && (eb.min_x <= x1_q) &&
                     (eb.max_y >= y0_q) && (eb.min_y <= y1_q);
  assign cand_hit  = lvl_ok && ov;
  assign id_eq     = (entry_id_q[eidx] == rid_q);
  assign multi     = (cmd_q == CMD_ALL_REACH) || (cmd_q == CMD_X_INTERVAL);
  assign at_end    = (idx_q == count_q) || (multi && (n_q == LIMIT_N));
  assign out_free  = !out_valid_q || m_axis_tready;
  assign ins_ok    = !dup_q && (count_q != COUNT_FULL);

  assign s_axis_tready = (state_q == ST_IDLE);

  // Next-state logic of the sequencer.
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    rid_d       = rid_q;
    lvl_d       = lvl_q;
    x0_d        = x0_q;
    y0_d        = y0_q;
    x1_d        = x1_q;
    y1_d        = y1_q;
    idx_d       = idx_q;
    n_d         = n_q;
    pend_d      = pend_q;
    pid_d       = pid_q;
    dup_d       = dup_q;
    count_d     = count_q;
    span_low_d  = span_low_q;
    span_high_d = span_high_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_hit_d   = out_hit_q;
    out_id_d    = out_id_q;
    out_last_d  = out_last_q;
    out_low_d   = out_low_q;
    out_high_d  = out_high_q;
    wr_en       = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_d  = s_axis_tuser;
          rid_d  = in_rid;
          lvl_d  = in_level;
          idx_d  = '0;
          n_d    = '0;
          pend_d = 1'b0;
          dup_d  = 1'b0;
          // Window corners wrap modulo 2^16.
          unique case (s_axis_tuser)
            CMD_POINT: begin
              x0_d = in_ax;
              y0_d = in_ay;
              x1_d = in_ax;
              y1_d = in_ay;
            end
            CMD_ANY_WINDOW: begin
              x0_d = in_ax;
              y0_d = in_ay;
              x1_d = in_ax + in_bx - 16'sd1;
              y1_d = in_ay + in_by - 16'sd1;
            end
            CMD_ALL_REACH: begin
              x0_d = in_ax - {{8{in_west[7]}}, in_west};
              x1_d = in_ax + {{8{in_east[7]}}, in_east};
              y0_d = in_ay - {{8{in_north[7]}}, in_north};
              y1_d = in_ay + {{8{in_south[7]}}, in_south};
            end
            CMD_X_INTERVAL: begin
              x0_d = in_ax;
              x1_d = in_bx;
              y0_d = COORD_MIN;
              y1_d = COORD_MAX;
            end
            default: begin
              // Insert keeps the raw bounds here.
              x0_d = in_ax;
              y0_d = in_ay;
              x1_d = in_bx;
              y1_d = in_by;
            end
          endcase
          if (s_axis_tuser == CMD_INSERT || s_axis_tuser == CMD_POINT ||
              s_axis_tuser == CMD_ANY_WINDOW || s_axis_tuser == CMD_ALL_REACH ||
              s_axis_tuser == CMD_X_INTERVAL) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end

      ST_SCAN: begin
        if (at_end) begin
          state_d = ST_FINISH;
        end else if (cmd_q == CMD_INSERT) begin
          // Duplicate id check.
          if (id_eq) begin
            dup_d   = 1'b1;
            state_d = ST_FINISH;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end else if (!multi) begin
          // First matching region ends the walk.
          if (cand_hit) begin
            pend_d  = 1'b1;
            pid_d   = entry_id_q[eidx];
            state_d = ST_FINISH;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end else if (cand_hit) begin
          // A held match goes out once the next one proves it is not last.
          if (!pend_q || out_free) begin
            if (pend_q) begin
              out_valid_d = 1'b1;
              out_hit_d   = 1'b1;
              out_id_d    = pid_q;
              out_last_d  = 1'b0;
              out_low_d   = span_low_q;
              out_high_d  = span_high_q;
            end
            pend_d = 1'b1;
            pid_d  = entry_id_q[eidx];
            n_d    = n_q + 1'b1;
            idx_d  = idx_q + 1'b1;
          end
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      ST_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_last_d  = 1'b1;
          out_hit_d   = 1'b0;
          out_id_d    = 8'd0;
          unique case (cmd_q)
            CMD_CLEAR: begin
              count_d     = '0;
              span_low_d  = SPAN_LOW_EMPTY;
              span_high_d = SPAN_HIGH_EMPTY;
            end
            CMD_INSERT: begin
              if (ins_ok) begin
                wr_en     = 1'b1;
                count_d   = count_q + 1'b1;
                out_hit_d = 1'b1;
                out_id_d  = rid_q;
                if (x0_q < span_low_q) begin
                  span_low_d = x0_q;
                end
                if (x1_q > span_high_q) begin
                  span_high_d = x1_q;
                end
              end
            end
            CMD_POINT, CMD_ANY_WINDOW, CMD_ALL_REACH, CMD_X_INTERVAL: begin
              out_hit_d = pend_q;
              out_id_d  = pend_q ? pid_q : 8'd0;
            end
            default: begin
              out_hit_d = 1'b0;
            end
          endcase
          out_low_d  = span_low_d;
          out_high_d = span_high_d;
          state_d    = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Sequencer state, spans and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      span_low_q  <= SPAN_LOW_EMPTY;
      span_high_q <= SPAN_HIGH_EMPTY;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      n_q         <= '0;
      pend_q      <= 1'b0;
      dup_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      span_low_q  <= span_low_d;
      span_high_q <= span_high_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      n_q         <= n_d;
      pend_q      <= pend_d;
      dup_q       <= dup_d;
    end
  end

  // Request and result payload.
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    rid_q      <= rid_d;
    lvl_q      <= lvl_d;
    x0_q       <= x0_d;
    y0_q       <= y0_d;
    x1_q       <= x1_d;
    y1_q       <= y1_d;
    pid_q      <= pid_d;
    out_hit_q  <= out_hit_d;
    out_id_q   <= out_id_d;
    out_last_q <= out_last_d;
    out_low_q  <= out_low_d;
    out_high_q <= out_high_d;
  end

  // Region storage write at the fill position.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_id_q[count_q[IDXW-1:0]]     <= rid_q;
      entry_level_q[count_q[IDXW-1:0]]  <= lvl_q;
      entry_bounds_q[count_q[IDXW-1:0]] <= '{max_y: y1_q, max_x: x1_q,
                                             min_y: y0_q, min_x: x0_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_high_q, out_low_q, out_id_q};
  assign m_axis_tuser  = out_hit_q;
  assign m_axis_tlast  = out_last_q;

  assign spans_empty = (span_low_q == SPAN_LOW_EMPTY) && (span_high_q == SPAN_HIGH_EMPTY);
  assign out_partial = m_axis_tvalid && !m_axis_tlast;
  assign out_miss    = m_axis_tvalid && !m_axis_tuser;

  // Checks on the sequencer and the stored state.
  `RROT_ASSERT_NEVER(a_count_range, clk_i, rst_ni, count_q > COUNT_FULL)
  `RROT_ASSERT_NEVER(a_match_limit, clk_i, rst_ni, n_q > LIMIT_N)
  `RROT_ASSERT(a_empty_spans, clk_i, rst_ni, (count_q == '0) |-> spans_empty)
  `RROT_ASSERT(a_partial_busy, clk_i, rst_ni, out_partial |-> (state_q != ST_IDLE))
  `RROT_ASSERT(a_miss_id_zero, clk_i, rst_ni, out_miss |-> (m_axis_tdata[7:0] == 8'd0))

endmodule

// ===== bench/tb_region_rectangle_overlap_table.sv =====
// ----------------------------------------------------------------------------
// Testbench for the region rectangle overlap table
// Drives commands on the input stream with random gaps and stalls on the
// output, predicts every result from a behavioral copy of the table and
// compares each result transfer field by field in order.
// ----------------------------------------------------------------------------
module tb_region_rectangle_overlap_table
  import rrot_pkg::*;
();

  // Command codes the block does not define.
  localparam logic [2:0] CMD_UNDEF_A = 3'd6;
  localparam logic [2:0] CMD_UNDEF_B = 3'd7;

  localparam int RANDOM_ITEMS = 125;
  localparam int IDLE_LIMIT   = 2000;
  // A command walks at most DEPTH entries; wait well past that.
  localparam int DRAIN_CYCLES = 2 * DEPTH + 8;

  // One command as it travels on the input stream.
  typedef struct packed {
    logic [2:0]         cmd;
    logic [7:0]         rid;
    logic signed [15:0] level;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] bx;
    logic signed [15:0] by;
    logic signed [7:0]  reach_north;
    logic signed [7:0]  reach_south;
    logic signed [7:0]  reach_east;
    logic signed [7:0]  reach_west;
  } region_cmd_t;

  // One result as it travels on the output stream.
  typedef struct packed {
    logic               hit;
    logic [7:0]         match_id;
    logic               last;
    logic signed [15:0] span_low;
    logic signed [15:0] span_high;
  } region_result_t;

  // One row of the directed stimulus; want is used only when typed is set.
  typedef struct {
    region_cmd_t    item;
    bit             typed;
    region_result_t want;
  } stim_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // From bit 0: region_id[8], level[16], ax[16], ay[16], bx[16], by[16],
  // reach_north[8], reach_south[8], reach_east[8], reach_west[8].
  logic [119:0] s_axis_tdata = '0;
  // From bit 0: cmd[3].
  logic [2:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // From bit 0: match_id[8], span_low[16], span_high[16].
  logic [39:0]  m_axis_tdata;
  // From bit 0: hit[1].
  logic         m_axis_tuser;
  logic         m_axis_tlast;

  region_rectangle_overlap_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Clock with a period of 10.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the region table.
  logic               tbl_valid  [DEPTH];
  logic [7:0]         tbl_id     [DEPTH];
  logic signed [15:0] tbl_level  [DEPTH];
  bounds_t            tbl_bounds [DEPTH];
  int                 tbl_count;
  logic signed [15:0] span_lo;
  logic signed [15:0] span_hi;

  region_result_t expected_results[$];
  stim_row_t      stim_rows[$];
  int             mismatch_count = 0;
  int             items_sent = 0;
  int             idle_cycles = 0;
  bit             src_quiet = 1'b0;
  int             sink_hold = 0;
  int             sink_quiet_left = 0;

  // Appends one result to the tail of the expected queue.
  function automatic void add_expected(region_result_t r);
    expected_results = {expected_results, r};
  endfunction

  // Appends one row to the directed stimulus table.
  function automatic void add_row(stim_row_t row);
    stim_rows = {stim_rows, row};
  endfunction

  // Empties the shadow table and restores the empty spans.
  function automatic void clear_table();
    for (int i = 0; i < DEPTH; i++) begin
      tbl_valid[i] = 1'b0;
    end
    tbl_count = 0;
    span_lo   = SPAN_LOW_EMPTY;
    span_hi   = SPAN_HIGH_EMPTY;
  endfunction

  // Inclusive rectangle overlap test.
  function automatic logic box_overlap(bounds_t b, logic signed [15:0] x0,
                                       logic signed [15:0] y0, logic signed [15:0] x1,
                                       logic signed [15:0] y1);
    return (b.max_x >= x0) && (b.min_x <= x1) && (b.max_y >= y0) && (b.min_y <= y1);
  endfunction

  // Applies one command to the shadow table and queues its results.
  function automatic int predict_results(region_cmd_t it);
    logic signed [15:0] x0, y0, x1, y1;
    logic               ok;
    region_result_t     r;
    int                 n;
    n          = 0;
    r.hit      = 1'b0;
    r.match_id = 8'h00;
    r.last     = 1'b1;
    case (it.cmd)
      CMD_CLEAR: begin
        clear_table();
      end
      CMD_INSERT: begin
        ok = (tbl_count < DEPTH);
        for (int i = 0; i < DEPTH; i++) begin
          if (tbl_valid[i] && tbl_id[i] == it.rid) ok = 1'b0;
        end
        if (ok) begin
          tbl_valid[tbl_count]  = 1'b1;
          tbl_id[tbl_count]     = it.rid;
          tbl_level[tbl_count]  = it.level;
          tbl_bounds[tbl_count] = '{max_y: it.by, max_x: it.bx, min_y: it.ay, min_x: it.ax};
          tbl_count++;
          if (it.ax < span_lo) span_lo = it.ax;
          if (it.bx > span_hi) span_hi = it.bx;
        end
        r.hit      = ok;
        r.match_id = ok ? it.rid : 8'h00;
      end
      CMD_POINT, CMD_ANY_WINDOW: begin
        x0 = it.ax;
        y0 = it.ay;
        x1 = it.ax;
        y1 = it.ay;
        // Window corners wrap modulo 2^16.
        if (it.cmd == CMD_ANY_WINDOW) begin
          x1 = it.ax + it.bx - 16'sd1;
          y1 = it.ay + it.by - 16'sd1;
        end
        for (int i = 0; i < DEPTH; i++) begin
          if (!r.hit && tbl_valid[i] && tbl_level[i] == it.level &&
              box_overlap(tbl_bounds[i], x0, y0, x1, y1)) begin
            r.hit      = 1'b1;
            r.match_id = tbl_id[i];
          end
        end
      end
      CMD_ALL_REACH, CMD_X_INTERVAL: begin
        if (it.cmd == CMD_ALL_REACH) begin
          x0 = it.ax - {{8{it.reach_west[7]}}, it.reach_west};
          x1 = it.ax + {{8{it.reach_east[7]}}, it.reach_east};
          y0 = it.ay - {{8{it.reach_north[7]}}, it.reach_north};
          y1 = it.ay + {{8{it.reach_south[7]}}, it.reach_south};
        end else begin
          x0 = it.ax;
          x1 = it.bx;
          y0 = COORD_MIN;
          y1 = COORD_MAX;
        end
        r.span_low  = span_lo;
        r.span_high = span_hi;
        // Every match in insertion order, up to the result limit.
        for (int i = 0; i < DEPTH; i++) begin
          if (n < RESULT_LIMIT && tbl_valid[i] &&
              (it.cmd == CMD_X_INTERVAL || tbl_level[i] == it.level) &&
              box_overlap(tbl_bounds[i], x0, y0, x1, y1)) begin
            r.hit      = 1'b1;
            r.match_id = tbl_id[i];
            r.last     = 1'b0;
            add_expected(r);
            n++;
          end
        end
        if (n > 0) begin
          expected_results[expected_results.size() - 1].last = 1'b1;
          return n;
        end
      end
      default: begin
      end
    endcase
    r.span_low  = span_lo;
    r.span_high = span_hi;
    add_expected(r);
    return 1;
  endfunction

  // Random gap length: mostly short, a few long.
  function automatic int pick_gap(bit quiet);
    int roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic region_cmd_t mk_item(logic [2:0] cmd, logic [7:0] rid,
                                          logic signed [15:0] level,
                                          logic signed [15:0] ax, logic signed [15:0] ay,
                                          logic signed [15:0] bx, logic signed [15:0] by,
                                          logic signed [7:0] rn, logic signed [7:0] rs,
                                          logic signed [7:0] re, logic signed [7:0] rw);
    region_cmd_t it;
    it = '{cmd, rid, level, ax, ay, bx, by, rn, rs, re, rw};
    return it;
  endfunction

  // Single final result as typed into the directed table.
  function automatic region_result_t one_result(logic hit, logic [7:0] id,
                                                logic signed [15:0] lo,
                                                logic signed [15:0] hi);
    region_result_t r;
    r = '{hit, id, 1'b1, lo, hi};
    return r;
  endfunction

  // Command with every field random.
  function automatic region_cmd_t rand_item();
    logic [127:0] raw;
    region_cmd_t  it;
    raw = {$urandom(), $urandom(), $urandom(), $urandom()};
    it  = raw[$bits(region_cmd_t)-1:0];
    return it;
  endfunction

  // Presents one command, waits for its transfer and predicts its results.
  // Called and returns at a falling edge.
  task automatic send_item(region_cmd_t it, bit typed, region_result_t want);
    int gap;
    gap = pick_gap(src_quiet);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = it.cmd;
    s_axis_tdata  = {it.reach_west, it.reach_east, it.reach_south, it.reach_north,
                     it.by, it.bx, it.ay, it.ax, it.level, it.rid};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    void'(predict_results(it));
    if (typed) begin
      expected_results[expected_results.size() - 1] = want;
    end
    items_sent++;
    @(negedge clk_i);
  endtask

  // One well-formed sequence: clear, a run of inserts around a locality and
  // queries aimed at that locality.
  task automatic run_episode(bit fill_up);
    region_cmd_t        it;
    logic signed [15:0] base_x, base_y;
    logic signed [15:0] lv [2];
    int                 n_ins, n_q;
    base_x = 16'($urandom());
    base_y = 16'($urandom());
    lv[0]  = 16'($urandom());
    lv[1]  = 16'($urandom());
    it     = rand_item();
    it.cmd = CMD_CLEAR;
    send_item(it, 1'b0, '0);
    if (fill_up) n_ins = DEPTH + 1;
    else if ($urandom_range(0, 4) == 0) n_ins = $urandom_range(DEPTH - 1, DEPTH + 2);
    else n_ins = $urandom_range(1, 8);
    for (int k = 0; k < n_ins; k++) begin
      it       = rand_item();
      it.cmd   = CMD_INSERT;
      // Now and then reuse an id that is already stored.
      if (!fill_up && tbl_count > 0 && $urandom_range(0, 5) == 0) begin
        it.rid = tbl_id[$urandom_range(0, tbl_count - 1)];
      end
      it.level = lv[$urandom_range(0, 1)];
      it.ax    = base_x + 16'($urandom_range(0, 80));
      it.ay    = base_y + 16'($urandom_range(0, 80));
      it.bx    = it.ax + 16'($urandom_range(0, 40));
      it.by    = it.ay + 16'($urandom_range(0, 40));
      if ($urandom_range(0, 9) == 0) it.bx = it.ax - 16'($urandom_range(1, 20));
      if ($urandom_range(0, 9) == 0) it.by = it.ay - 16'($urandom_range(1, 20));
      send_item(it, 1'b0, '0);
    end
    n_q = $urandom_range(3, 10);
    for (int q = 0; q < n_q; q++) begin
      it     = rand_item();
      it.cmd = CMD_POINT + 3'($urandom_range(0, 3));
      if ($urandom_range(0, 7) != 0) it.level = lv[$urandom_range(0, 1)];
      it.ax = base_x + 16'($urandom_range(0, 120));
      it.ay = base_y + 16'($urandom_range(0, 120));
      case (it.cmd)
        CMD_ANY_WINDOW: begin
          if ($urandom_range(0, 7) != 0) begin
            it.bx = 16'($urandom_range(0, 40));
            it.by = 16'($urandom_range(0, 40));
          end
        end
        CMD_ALL_REACH: begin
          if ($urandom_range(0, 3) != 0) begin
            it.reach_north = 8'($urandom_range(0, 60));
            it.reach_south = 8'($urandom_range(0, 60));
            it.reach_east  = 8'($urandom_range(0, 60));
            it.reach_west  = 8'($urandom_range(0, 60));
          end
        end
        CMD_X_INTERVAL: begin
          if ($urandom_range(0, 7) != 0) it.bx = it.ax + 16'($urandom_range(0, 60));
        end
        default: begin
        end
      endcase
      // The filling sequence asks once for every region in the table.
      if (fill_up && q == 0) begin
        it.cmd = CMD_X_INTERVAL;
        it.ax  = COORD_MIN;
        it.bx  = COORD_MAX;
      end
      send_item(it, 1'b0, '0);
    end
  endtask

  // Result side: random stalls with stretches of steady readiness.
  always @(negedge clk_i) begin
    if (sink_quiet_left > 0) sink_quiet_left--;
    else if ($urandom_range(0, 199) == 0) sink_quiet_left = $urandom_range(50, 200);
    if (sink_hold > 0) begin
      m_axis_tready = 1'b0;
      sink_hold--;
    end else begin
      m_axis_tready = 1'b1;
      if (sink_quiet_left == 0) sink_hold = pick_gap(1'b0);
    end
  end

  // Compare every result transfer with the oldest expectation.
  always @(posedge clk_i) begin : result_check
    region_result_t seen, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen = '{m_axis_tuser, m_axis_tdata[7:0], m_axis_tlast,
               m_axis_tdata[23:8], m_axis_tdata[39:24]};
      if (expected_results.size() == 0) begin
        $error("result transfer with no expectation pending");
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (seen.hit !== want.hit) begin
          $error("hit mismatch: expected %0d, actual %0d", want.hit, seen.hit);
          mismatch_count++;
        end
        if (seen.match_id !== want.match_id) begin
          $error("match_id mismatch: expected %0d, actual %0d", want.match_id,
                 seen.match_id);
          mismatch_count++;
        end
        if (seen.last !== want.last) begin
          $error("last mismatch: expected %0d, actual %0d", want.last, seen.last);
          mismatch_count++;
        end
        if (seen.span_low !== want.span_low) begin
          $error("span_low mismatch: expected %0d, actual %0d", want.span_low,
                 seen.span_low);
          mismatch_count++;
        end
        if (seen.span_high !== want.span_high) begin
          $error("span_high mismatch: expected %0d, actual %0d", want.span_high,
                 seen.span_high);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL region_rectangle_overlap_table");
      $finish;
    end
  end

  initial begin
    region_cmd_t    it;
    region_result_t none;
    bit             first;
    none = one_result(1'b0, 8'h00, SPAN_LOW_EMPTY, SPAN_HIGH_EMPTY);
    clear_table();

    // Directed rows: empty table, undefined commands, extreme inserts,
    // duplicate id, inverted bounds, window wrap and empty windows, clear.
    add_row('{mk_item(CMD_POINT, 8'h00, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                      8'sd0, 8'sd0, 8'sd0, 8'sd0), 1'b1, none});
    add_row('{mk_item(CMD_ALL_REACH, 8'h00, 16'sd0, COORD_MAX, COORD_MIN,
                      16'sd0, 16'sd0, -8'sd128, 8'sd127, 8'sd127, -8'sd128),
              1'b1, none});
    add_row('{mk_item(CMD_X_INTERVAL, 8'h00, 16'sd0, COORD_MIN, 16'sd0,
                      COORD_MAX, 16'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0),
              1'b1, none});
    add_row('{mk_item(CMD_UNDEF_A, 8'hFF, -16'sd1, -16'sd1, -16'sd1, -16'sd1,
                      -16'sd1, -8'sd1, -8'sd1, -8'sd1, -8'sd1), 1'b1, none});
    add_row('{mk_item(CMD_UNDEF_B, 8'h01, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                      16'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0), 1'b1, none});
    add_row('{mk_item(CMD_INSERT, 8'h00, COORD_MIN, COORD_MIN, COORD_MIN,
                      COORD_MAX, COORD_MAX, 8'sd0, 8'sd0, 8'sd0, 8'sd0),
              1'b1, one_result(1'b1, 8'h00, COORD_MIN, COORD_MAX)});
    add_row('{mk_item(CMD_INSERT, 8'hFF, COORD_MAX, 16'sd10, 16'sd20, 16'sd30,
                      16'sd40, 8'sd0, 8'sd0, 8'sd0, 8'sd0),
              1'b1, one_result(1'b1, 8'hFF, COORD_MIN, COORD_MAX)});
    add_row('{mk_item(CMD_INSERT, 8'hFF, 16'sd0, 16'sd0, 16'sd0, 16'sd5,
                      16'sd5, 8'sd0, 8'sd0, 8'sd0, 8'sd0),
              1'b1, one_result(1'b0, 8'h00, COORD_MIN, COORD_MAX)});
    add_row('{mk_item(CMD_INSERT, 8'h55, COORD_MAX, 16'sd100, 16'sd50,
                      -16'sd100, 16'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0),
              1'b0, none});
    add_row('{mk_item(CMD_POINT, 8'h00, COORD_MIN, 16'sd0, 16'sd0, 16'sd0,
                      16'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0), 1'b0, none});
    add_row('{mk_item(CMD_POINT, 8'h00, COORD_MAX, 16'sd20, 16'sd30, 16'sd0,
                      16'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0), 1'b0, none});
    add_row('{mk_item(CMD_ANY_WINDOW, 8'h00, COORD_MAX, 16'sd10, 16'sd20,
                      16'sd0, 16'sd5, 8'sd0, 8'sd0, 8'sd0, 8'sd0), 1'b0, none});
    add_row('{mk_item(CMD_ANY_WINDOW, 8'h00, COORD_MAX, COORD_MIN, 16'sd0,
                      -16'sd1, 16'sd100, 8'sd0, 8'sd0, 8'sd0, 8'sd0),
              1'b0, none});
    add_row('{mk_item(CMD_ANY_WINDOW, 8'h00, COORD_MAX, COORD_MAX, 16'sd20,
                      16'sd2, 16'sd2, 8'sd0, 8'sd0, 8'sd0, 8'sd0), 1'b0, none});
    add_row('{mk_item(CMD_ALL_REACH, 8'h00, COORD_MAX, 16'sd20, 16'sd30,
                      16'sd0, 16'sd0, 8'sd127, 8'sd127, 8'sd127, 8'sd127),
              1'b0, none});
    add_row('{mk_item(CMD_ALL_REACH, 8'h00, COORD_MAX, 16'sd20, 16'sd30,
                      16'sd0, 16'sd0, -8'sd128, -8'sd128, -8'sd128, -8'sd128),
              1'b0, none});
    add_row('{mk_item(CMD_X_INTERVAL, 8'h00, 16'sd0, COORD_MIN, 16'sd0,
                      COORD_MAX, 16'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0),
              1'b0, none});
    add_row('{mk_item(CMD_X_INTERVAL, 8'h00, 16'sd0, 16'sd100, 16'sd0,
                      -16'sd100, 16'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0),
              1'b0, none});
    add_row('{mk_item(CMD_ALL_REACH, 8'h00, COORD_MIN, COORD_MAX, COORD_MAX,
                      16'sd0, 16'sd0, 8'sd127, 8'sd127, 8'sd127, 8'sd127),
              1'b0, none});
    add_row('{mk_item(CMD_CLEAR, 8'h00, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                      16'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0), 1'b1, none});
    add_row('{mk_item(CMD_INSERT, 8'h80, 16'sd0, -16'sd5, 16'sd0, 16'sd5,
                      16'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0),
              1'b1, one_result(1'b1, 8'h80, -16'sd5, 16'sd5)});
    add_row('{mk_item(CMD_X_INTERVAL, 8'h00, 16'sd0, -16'sd5, 16'sd0,
                      -16'sd5, 16'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0),
              1'b0, none});

    // Reset is held low, then released at a falling edge.
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part.
    foreach (stim_rows[k]) begin
      send_item(stim_rows[k].item, stim_rows[k].typed, stim_rows[k].want);
    end

    // Random part: mostly well-formed sequences, some pure noise.
    first = 1'b1;
    while (items_sent < stim_rows.size() + RANDOM_ITEMS) begin
      src_quiet = ($urandom_range(0, 3) == 0);
      if (first || $urandom_range(0, 4) != 0) begin
        run_episode(first);
        first = 1'b0;
      end else begin
        repeat ($urandom_range(2, 6)) begin
          it = rand_item();
          send_item(it, 1'b0, '0);
        end
      end
    end
    s_axis_tvalid = 1'b0;

    // Drain the outstanding results, then let the block settle.
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS region_rectangle_overlap_table");
    end else begin
      $display("FAIL region_rectangle_overlap_table");
    end
    $finish;
  end

endmodule
